@@ hw/rtl/pplq_pkg.sv @@
// pplq_pkg: beat types, register indexes, query kinds and datapath widths
// for the plane point and line query pipeline; no dependencies
package pplq_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_A      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_B      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_C      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PARALLEL_THR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COPLANAR_THR = 3'd4;

  localparam logic [1:0] KIND_LINE    = 2'd0;
  localparam logic [1:0] KIND_PROJECT = 2'd1;
  localparam logic [1:0] KIND_REFLECT = 2'd2;

  localparam int COORD_W = 16;   // coordinate fields
  localparam int DIFF_W  = 17;   // coordinate differences
  localparam int PROD_W  = 34;   // cross product terms
  localparam int NRM_W   = 35;   // normal components, signed
  localparam int DOT_W   = 52;   // one n*w term
  localparam int SUM_W   = 54;   // s and n.dir, signed
  localparam int MAG_W   = 53;   // magnitude of s and n.dir
  localparam int MUL_A_W = 34;   // |n| or |d|
  localparam int SQN_W   = 68;   // one n_i^2
  localparam int NN_W    = 70;   // n.n
  localparam int M_W     = 87;   // |a|*|s|
  localparam int NUM_W   = 98;   // (m<<9 or m<<10)+den
  localparam int DEN2_W  = 71;   // 2den
  localparam int SQ_W    = 106;  // s^2
  localparam int QUOT_W  = 41;   // rounded quotient bits before clamp
  localparam int DIST_Q_W = 64;
  localparam int ROOT_W  = 32;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] end_z;
  } query_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        plane_distance;
    logic               on_plane;
  } result_t;

  // plane terms handed from the front end to the divide section
  typedef struct packed {
    logic [1:0]                       kind;
    logic [2:0][COORD_W-1:0]          p;
    logic [2:0][DIFF_W-1:0]           d;
    logic [2:0][NRM_W-1:0]            n;
    logic [SUM_W-1:0]                 s;
    logic [SUM_W-1:0]                 nv;
    logic [NN_W-1:0]                  nn;
  } plane_terms_t;

endpackage

@@ hw/rtl/pplq_front.sv @@
// pplq_front: six-stage front end forming the plane normal, s = n.(p-a),
// n.dir and n.n for each query beat; uses pplq_pkg
module pplq_front
  import pplq_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  query_t       query,
  input  logic [47:0]  point_a,
  input  logic [47:0]  point_b,
  input  logic [47:0]  point_c,
  output logic         terms_valid,
  output plane_terms_t terms
);

  localparam int CW_EFF = (COORD_WIDTH < COORD_W) ? COORD_WIDTH : COORD_W;
  localparam int SX = COORD_W - CW_EFF;

  function automatic logic signed [COORD_W-1:0] sext(input logic [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] t;
    t = signed'(v << SX);
    return t >>> SX;
  endfunction

  logic signed [COORD_W-1:0] pin [3];
  logic signed [COORD_W-1:0] qin [3];
  logic signed [COORD_W-1:0] ain [3];
  logic signed [COORD_W-1:0] bin [3];
  logic signed [COORD_W-1:0] cin [3];

  always_comb begin
    pin[0] = sext(query.point_x);
    pin[1] = sext(query.point_y);
    pin[2] = sext(query.point_z);
    qin[0] = sext(query.end_x);
    qin[1] = sext(query.end_y);
    qin[2] = sext(query.end_z);
    ain[0] = sext(point_a[47:32]);
    ain[1] = sext(point_a[31:16]);
    ain[2] = sext(point_a[15:0]);
    bin[0] = sext(point_b[47:32]);
    bin[1] = sext(point_b[31:16]);
    bin[2] = sext(point_b[15:0]);
    cin[0] = sext(point_c[47:32]);
    cin[1] = sext(point_c[31:16]);
    cin[2] = sext(point_c[15:0]);
  end

  logic [5:0] v;
  logic [1:0] kind [5];
  logic signed [COORD_W-1:0] p1 [3], p2 [3], p3 [3], p4 [3], p5 [3];
  logic signed [DIFF_W-1:0]  d1 [3], d2 [3], d3 [3], d4 [3], d5 [3];
  logic signed [DIFF_W-1:0]  e1 [3], f1 [3], w1 [3], w2 [3], w3 [3];
  logic signed [PROD_W-1:0]  pr2 [6];
  logic signed [NRM_W-1:0]   n3 [3], n4 [3], n5 [3];
  logic signed [DOT_W-1:0]   nw4 [3], nd4 [3];
  logic [PROD_W-1:0]         hh4 [3], hl4 [3], ll4 [3];
  logic [MUL_A_W-1:0]        nmag [3];
  logic signed [SUM_W-1:0]   s5, nv5;
  logic [SQN_W-1:0]          sq5 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag[i] = MUL_A_W'((n3[i] < 0) ? -n3[i] : n3[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind[0] <= query.kind;
      for (int k = 1; k < 5; k++) kind[k] <= kind[k-1];
      for (int i = 0; i < 3; i++) begin
        // stage 1: differences
        p1[i] <= pin[i];
        d1[i] <= DIFF_W'(qin[i]) - DIFF_W'(pin[i]);
        w1[i] <= DIFF_W'(pin[i]) - DIFF_W'(ain[i]);
        e1[i] <= DIFF_W'(bin[i]) - DIFF_W'(ain[i]);
        f1[i] <= DIFF_W'(cin[i]) - DIFF_W'(ain[i]);
        // stage 2
        p2[i] <= p1[i];
        d2[i] <= d1[i];
        w2[i] <= w1[i];
        // stage 3
        p3[i] <= p2[i];
        d3[i] <= d2[i];
        w3[i] <= w2[i];
        // stage 4: dot terms and split squares of |n|
        p4[i]  <= p3[i];
        d4[i]  <= d3[i];
        n4[i]  <= n3[i];
        nw4[i] <= n3[i] * w3[i];
        nd4[i] <= n3[i] * d3[i];
        hh4[i] <= nmag[i][33:17] * nmag[i][33:17];
        hl4[i] <= nmag[i][33:17] * nmag[i][16:0];
        ll4[i] <= nmag[i][16:0] * nmag[i][16:0];
        // stage 5
        p5[i]  <= p4[i];
        d5[i]  <= d4[i];
        n5[i]  <= n4[i];
        sq5[i] <= (SQN_W'(hh4[i]) << 34) + (SQN_W'(hl4[i]) << 18) + SQN_W'(ll4[i]);
      end
      pr2[0] <= e1[1] * f1[2];
      pr2[1] <= e1[2] * f1[1];
      pr2[2] <= e1[2] * f1[0];
      pr2[3] <= e1[0] * f1[2];
      pr2[4] <= e1[0] * f1[1];
      pr2[5] <= e1[1] * f1[0];
      n3[0] <= NRM_W'(pr2[0]) - NRM_W'(pr2[1]);
      n3[1] <= NRM_W'(pr2[2]) - NRM_W'(pr2[3]);
      n3[2] <= NRM_W'(pr2[4]) - NRM_W'(pr2[5]);
      s5  <= SUM_W'(nw4[0]) + SUM_W'(nw4[1]) + SUM_W'(nw4[2]);
      nv5 <= SUM_W'(nd4[0]) + SUM_W'(nd4[1]) + SUM_W'(nd4[2]);
      // stage 6: output register
      terms.kind <= kind[4];
      for (int i = 0; i < 3; i++) begin
        terms.p[i] <= p5[i];
        terms.d[i] <= d5[i];
        terms.n[i] <= n5[i];
      end
      terms.s  <= s5;
      terms.nv <= nv5;
      terms.nn <= NN_W'(sq5[0]) + NN_W'(sq5[1]) + NN_W'(sq5[2]);
    end
  end

  assign terms_valid = v[5];

endmodule

@@ hw/rtl/pplq_div.sv @@
// pplq_div: pipelined restoring divider, one quotient bit per stage;
// the caller keeps the starting remainder below the divisor; uses pplq_pkg
module pplq_div
  import pplq_pkg::*;
#(
  parameter int DEN_W = 71,
  parameter int QB    = 41
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] rem_in,
  input  logic [QB-1:0]    low_in,
  input  logic [DEN_W-1:0] den_in,
  output logic [QB-1:0]    quot
);

  logic [DEN_W-1:0] rem_r [QB-1];
  logic [QB-1:0]    low_r [QB-1];
  logic [DEN_W-1:0] den_r [QB-1];
  logic [QB-1:0]    q_r   [QB];

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DEN_W-1:0] rem_src, den_src;
    logic [QB-1:0]    low_src, q_src, q_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W+1:0] diff;

    if (k == 0) begin : g_first
      assign rem_src = rem_in;
      assign low_src = low_in;
      assign den_src = den_in;
      assign q_src   = '0;
    end else begin : g_rest
      assign rem_src = rem_r[k-1];
      assign low_src = low_r[k-1];
      assign den_src = den_r[k-1];
      assign q_src   = q_r[k-1];
    end

    always_comb begin
      trial  = {rem_src, low_src[QB-1-k]};
      diff   = {1'b0, trial} - (DEN_W+2)'(den_src);
      q_next = q_src;
      q_next[QB-1-k] = ~diff[DEN_W+1];
    end

    always_ff @(posedge clk) begin
      if (en) q_r[k] <= q_next;
    end

    if (k < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          low_r[k] <= low_src;
          den_r[k] <= den_src;
          rem_r[k] <= diff[DEN_W+1] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
        end
      end
    end
  end

  assign quot = q_r[QB-1];

endmodule

@@ hw/rtl/pplq_sqrt.sv @@
// pplq_sqrt: pipelined integer square root, one root bit per stage
// uses pplq_pkg for the root width
module pplq_sqrt
  import pplq_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [2*ROOT_W-1:0] radicand,
  output logic [ROOT_W-1:0]   root
);

  localparam int RAD_W = 2 * ROOT_W;

  logic [RAD_W-1:0] op_r  [ROOT_W-1];
  logic [RAD_W-1:0] res_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam logic [RAD_W-1:0] ONE = RAD_W'(1) << (2 * (ROOT_W - 1 - k));
    logic [RAD_W-1:0] op_src, res_src, trial;
    logic             take;

    if (k == 0) begin : g_first
      assign op_src  = radicand;
      assign res_src = '0;
    end else begin : g_rest
      assign op_src  = op_r[k-1];
      assign res_src = res_r[k-1];
    end

    assign trial = res_src + ONE;
    assign take  = op_src >= trial;

    always_ff @(posedge clk) begin
      if (en) res_r[k] <= take ? ((res_src >> 1) + ONE) : (res_src >> 1);
    end

    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) op_r[k] <= take ? (op_src - trial) : op_src;
      end
    end
  end

  assign root = res_r[ROOT_W-1][ROOT_W-1:0];

endmodule

@@ hw/rtl/pplq_dly.sv @@
// pplq_dly: enabled shift line that lines up payload with the longer
// divide and root path; no dependencies
module pplq_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int k = 1; k < DEPTH; k++) taps[k] <= taps[k-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

@@ hw/rtl/plane_point_and_line_queries.sv @@
// plane_point_and_line_queries: top level, config registers, divide setup,
// result assembly; uses pplq_pkg, pplq_front, pplq_div, pplq_sqrt, pplq_dly
//
//   channel | direction | handshake               | beat
//   query   | in        | query_valid/query_stall | query_t
//   result  | out       | result_valid/result_stall | result_t
//   cfg     | in        | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// one query beat per cycle while result_stall does not hold the pipeline; each
// result passes 6 front-end stages, 5 setup stages, 64 distance divide stages and
// 32 root stages, then the output register. the distance divide and root set the
// depth the whole pipeline holds while a result waits under result_stall
// synchronous active-high rst clears valid bits and loads the config reset values
module plane_point_and_line_queries
  import pplq_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  query_valid,
  output logic                  query_stall,
  input  query_t                query,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SIDE_DEPTH = DIST_Q_W + ROOT_W;
  localparam int QUOT_PAD   = SIDE_DEPTH - QUOT_W;
  localparam logic [QUOT_W-1:0] TERM_CLAMP = QUOT_W'(1) << (QUOT_W - 1);
  localparam logic signed [42:0] SAT_HI = 43'sd2147483647;
  localparam logic signed [42:0] SAT_LO = -43'sd2147483648;

  typedef struct packed {
    logic [1:0]              kind;
    logic                    found;
    logic [2:0]              neg;
    logic [2:0][COORD_W-1:0] p;
  } carry_t;

  typedef struct packed {
    carry_t     cy;
    logic [2:0] ovf;
    logic       dist_ovf;
  } side_t;

  logic en;
  assign en          = !(result_valid && result_stall);
  assign query_stall = !en;
  assign cfg_ready   = 1'b1;

  // configuration registers
  logic [47:0] pt_a, pt_b, pt_c;
  logic [31:0] par_thr, cop_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_a    <= '0;
      pt_b    <= '0;
      pt_c    <= '0;
      par_thr <= 32'd1;
      cop_thr <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POINT_A:      pt_a    <= cfg_data;
        REG_POINT_B:      pt_b    <= cfg_data;
        REG_POINT_C:      pt_c    <= cfg_data;
        REG_PARALLEL_THR: par_thr <= cfg_data[31:0];
        REG_COPLANAR_THR: cop_thr <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic         terms_valid;
  plane_terms_t terms;

  pplq_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (query_valid),
    .query       (query),
    .point_a     (pt_a),
    .point_b     (pt_b),
    .point_c     (pt_c),
    .terms_valid (terms_valid),
    .terms       (terms)
  );

  // setup stage 1: magnitudes, signs, special cases
  logic signed [SUM_W-1:0] s_v, nv_v;
  logic [MAG_W-1:0]        s_mag, nv_mag;
  logic                    parallel;
  logic [MUL_A_W-1:0]      amul [3];
  carry_t                  cy_in;
  logic [NN_W-1:0]         den_in;

  always_comb begin
    s_v      = $signed(terms.s);
    nv_v     = $signed(terms.nv);
    s_mag    = MAG_W'((s_v < 0) ? -s_v : s_v);
    nv_mag   = MAG_W'((nv_v < 0) ? -nv_v : nv_v);
    parallel = (nv_v == '0) || (nv_mag < MAG_W'({par_thr, 8'b0}));
    cy_in.kind = terms.kind;
    for (int i = 0; i < 3; i++) begin
      logic signed [NRM_W-1:0]  nl;
      logic signed [DIFF_W-1:0] dl;
      nl = $signed(terms.n[i]);
      dl = $signed(terms.d[i]);
      cy_in.p[i] = terms.p[i];
      if (terms.kind == KIND_LINE) begin
        amul[i]      = MUL_A_W'((dl < 0) ? -dl : dl);
        cy_in.neg[i] = (dl < 0) ^ (s_v < 0) ^ (nv_v < 0);
      end else begin
        amul[i]      = MUL_A_W'((nl < 0) ? -nl : nl);
        cy_in.neg[i] = (nl < 0) ^ (s_v < 0);
      end
    end
    den_in = (terms.kind == KIND_LINE) ? NN_W'(nv_mag) : terms.nn;
    case (terms.kind)
      KIND_LINE:    cy_in.found = !parallel;
      KIND_PROJECT: cy_in.found = (terms.nn != '0);
      KIND_REFLECT: cy_in.found = (terms.nn != '0);
      default:      cy_in.found = 1'b0;
    endcase
  end

  logic [4:0]         vt;
  carry_t             cy [5];
  logic [MUL_A_W-1:0] amul_a [3];
  logic [MAG_W-1:0]   smag_a;
  logic [NN_W-1:0]    den_a, den_b, den_c, nn_a, nn_b, nn_c, nn_d, nn_e;
  logic [43:0]        pp_hh [3], pp_lh [3];
  logic [42:0]        pp_hl [3], pp_ll [3];
  logic [53:0]        sq_hh;
  logic [52:0]        sq_hl;
  logic [51:0]        sq_ll;
  logic [M_W-1:0]     m_c [3];
  logic [SQ_W-1:0]    sq_c, sq_d;
  logic [NUM_W-1:0]   num_d [3];
  logic [DEN2_W-1:0]  den2_d, den2_e;
  logic [NUM_W-1:0]   num_e [3];
  logic [SQ_W-1:0]    sq_e;
  logic [2:0]         ovf_e;
  logic               dist_ovf_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= '0;
    end else if (en) begin
      vt <= {vt[3:0], terms_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cy[0] <= cy_in;
      for (int k = 1; k < 5; k++) cy[k] <= cy[k-1];
      // stage 1
      smag_a <= s_mag;
      den_a  <= den_in;
      nn_a   <= terms.nn;
      for (int i = 0; i < 3; i++) amul_a[i] <= amul[i];
      // stage 2: partial products
      for (int i = 0; i < 3; i++) begin
        pp_hh[i] <= amul_a[i][33:17] * smag_a[52:26];
        pp_hl[i] <= amul_a[i][33:17] * smag_a[25:0];
        pp_lh[i] <= amul_a[i][16:0] * smag_a[52:26];
        pp_ll[i] <= amul_a[i][16:0] * smag_a[25:0];
      end
      sq_hh <= smag_a[52:26] * smag_a[52:26];
      sq_hl <= smag_a[52:26] * smag_a[25:0];
      sq_ll <= smag_a[25:0] * smag_a[25:0];
      den_b <= den_a;
      nn_b  <= nn_a;
      // stage 3: recombine
      for (int i = 0; i < 3; i++) begin
        m_c[i] <= (M_W'(pp_hh[i]) << 43) + (M_W'(pp_hl[i]) << 17)
                + (M_W'(pp_lh[i]) << 26) + M_W'(pp_ll[i]);
      end
      sq_c  <= (SQ_W'(sq_hh) << 52) + (SQ_W'(sq_hl) << 27) + SQ_W'(sq_ll);
      den_c <= den_b;
      nn_c  <= nn_b;
      // stage 4: rounded-division operands, (m<<9)+den over 2den, m<<10 for reflect
      for (int i = 0; i < 3; i++) begin
        num_d[i] <= ((cy[2].kind == KIND_REFLECT) ? (NUM_W'(m_c[i]) << 10)
                                                  : (NUM_W'(m_c[i]) << 9))
                  + NUM_W'(den_c);
      end
      den2_d <= {den_c, 1'b0};
      sq_d   <= sq_c;
      nn_d   <= nn_c;
      // stage 5: quotient overflow checks
      for (int i = 0; i < 3; i++) begin
        num_e[i] <= num_d[i];
        ovf_e[i] <= DEN2_W'(num_d[i][NUM_W-1:QUOT_W]) >= den2_d;
      end
      den2_e     <= den2_d;
      sq_e       <= sq_d;
      nn_e       <= nn_d;
      dist_ovf_e <= NN_W'(sq_d[SQ_W-1:48]) >= nn_d;
    end
  end

  // dividers
  logic [2:0][QUOT_W-1:0] quot, quot_al;
  logic [DIST_Q_W-1:0]    dist_q;
  logic [ROOT_W-1:0]      root;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    pplq_div #(.DEN_W(DEN2_W), .QB(QUOT_W)) u_div (
      .clk    (clk),
      .en     (en),
      .rem_in (DEN2_W'(num_e[i][NUM_W-1:QUOT_W])),
      .low_in (num_e[i][QUOT_W-1:0]),
      .den_in (den2_e),
      .quot   (quot[i])
    );
  end

  pplq_dly #(.WIDTH(3 * QUOT_W), .DEPTH(QUOT_PAD)) u_quot_dly (
    .clk  (clk),
    .en   (en),
    .din  (quot),
    .dout (quot_al)
  );

  pplq_div #(.DEN_W(NN_W), .QB(DIST_Q_W)) u_dist_div (
    .clk    (clk),
    .en     (en),
    .rem_in (NN_W'(sq_e[SQ_W-1:48])),
    .low_in ({sq_e[47:0], 16'b0}),
    .den_in (nn_e),
    .quot   (dist_q)
  );

  pplq_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (dist_q),
    .root     (root)
  );

  // sideband and valid bits follow the longest path
  side_t side_in, side_out;
  logic [SIDE_DEPTH-1:0] vside;

  assign side_in = '{cy: cy[4], ovf: ovf_e, dist_ovf: dist_ovf_e};

  pplq_dly #(.WIDTH($bits(side_t)), .DEPTH(SIDE_DEPTH)) u_side_dly (
    .clk  (clk),
    .en   (en),
    .din  (side_in),
    .dout (side_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vside <= '0;
    end else if (en) begin
      vside <= {vside[SIDE_DEPTH-2:0], vt[4]};
    end
  end

  // result assembly
  result_t           res_next;
  logic signed [42:0] coord [3];
  logic [31:0]        dist_out;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [QUOT_W-1:0]  tmag;
      logic signed [42:0] term;
      tmag = (side_out.ovf[i] || (quot_al[i] > TERM_CLAMP)) ? TERM_CLAMP : quot_al[i];
      term = side_out.cy.neg[i] ? -$signed(43'(tmag)) : $signed(43'(tmag));
      coord[i] = (43'($signed(side_out.cy.p[i])) <<< 8) - term;
      if (coord[i] > SAT_HI) coord[i] = SAT_HI;
      if (coord[i] < SAT_LO) coord[i] = SAT_LO;
    end
    dist_out = side_out.dist_ovf ? '1 : root;
    res_next = '0;
    if (side_out.cy.found) begin
      res_next.found = 1'b1;
      res_next.out_x = coord[0][31:0];
      res_next.out_y = coord[1][31:0];
      res_next.out_z = coord[2][31:0];
      if (side_out.cy.kind == KIND_PROJECT) begin
        res_next.plane_distance = dist_out;
        res_next.on_plane       = dist_out < cop_thr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= vside[SIDE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) result <= res_next;
  end

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.out_x == '0 && result.out_y == '0
      && result.out_z == '0 && result.plane_distance == '0 && !result.on_plane)
    else $error("miss beat carries nonzero fields");

  a_on_plane_found: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.on_plane |-> result.found && result.plane_distance < cop_thr)
    else $error("coplanar flag without a close projection");

  a_front_handoff: assert property (@(posedge clk) disable iff (rst)
    terms_valid && en |=> vt[0])
    else $error("front-end beat lost at setup stage");

endmodule
